FILE: rtl/pixel_tone_curve_adjust_unit_macros.svh
// Assertion macros used by the tone curve RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef PIXEL_TONE_CURVE_ADJUST_UNIT_MACROS_SVH
`define PIXEL_TONE_CURVE_ADJUST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PTCA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle pipeline check failed");

`define PTCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle pipeline check failed");

`else

`define PTCA_ASSERT_IMPLY(lbl, ante, cons)

`define PTCA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/ptca_pkg.sv
package ptca_pkg;

    localparam int unsigned StrengthWidth = 13;
    localparam int unsigned BandWidth     = 15;
    localparam int unsigned WarmProdWidth = 21;
    localparam int unsigned WarmFullWidth = 28;

    // Luma weights and band thresholds.
    localparam logic [15:0] LumaCoefR = 16'd76;
    localparam logic [15:0] LumaCoefG = 16'd150;
    localparam logic [15:0] LumaCoefB = 16'd29;

    localparam logic [7:0] LumaEdge0 = 8'd26;
    localparam logic [7:0] LumaEdge1 = 8'd77;
    localparam logic [7:0] LumaEdge2 = 8'd179;
    localparam logic [7:0] LumaEdge3 = 8'd230;

    // Warm term weights and its final gain.
    localparam logic [15:0] WarmCoefR = 16'd153;
    localparam logic [15:0] WarmCoefG = 16'd77;
    localparam logic [15:0] WarmCoefB = 16'd26;
    localparam logic signed [WarmFullWidth-1:0] WarmGain = 28'sd77;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } pixel_t;

    typedef struct packed {
        pixel_t             pix;
        logic signed [BandWidth-1:0]     band;
        logic signed [WarmProdWidth-1:0] warm_prod;
    } color_data_t;

    typedef struct packed {
        pixel_t             pix;
        logic signed [BandWidth-1:0] total;
    } offset_data_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_load_t;

endpackage

FILE: rtl/ptca_color_stage.sv
module ptca_color_stage
    import ptca_pkg::*;
(
    input  logic                            clk,
    input  pipe_load_t                      load,
    input  logic signed [StrengthWidth-1:0] strength,
    input  pixel_t                          pix_in,
    output color_data_t                     data_out
);

    pixel_t                 pix1_reg;
    logic [15:0]            luma_sum_reg;
    logic signed [16:0]     warm_sum_reg;

    logic [15:0]            luma_sum_next;
    logic signed [16:0]     warm_sum_next;

    logic [7:0]             luma;
    logic [7:0]             warm_byte;
    logic signed [BandWidth-1:0]     strength_ext;
    logic signed [BandWidth-1:0]     band_next;
    logic signed [WarmProdWidth-1:0] warm_ext;
    logic signed [WarmProdWidth-1:0] strength_wide;
    color_data_t            data_reg;
    color_data_t            data_next;

    // First step: the two weighted sums of the channels.
    always_comb
    begin
        luma_sum_next = LumaCoefR * {8'd0, pix_in.red}
                      + LumaCoefG * {8'd0, pix_in.green}
                      + LumaCoefB * {8'd0, pix_in.blue};
        warm_sum_next = $signed({1'b0, 16'(WarmCoefR * {8'd0, pix_in.red}
                                          + WarmCoefG * {8'd0, pix_in.green})})
                      - $signed({1'b0, 16'(WarmCoefB * {8'd0, pix_in.blue})});
    end

    always_ff @(posedge clk)
    begin
        if (load.ld1)
        begin
            pix1_reg     <= pix_in;
            luma_sum_reg <= luma_sum_next;
            warm_sum_reg <= warm_sum_next;
        end
    end

    // Second step: band offset and the first product of the warm term.
    always_comb
    begin
        luma         = luma_sum_reg[15:8];
        strength_ext = {{(BandWidth - StrengthWidth){strength[StrengthWidth-1]}}, strength};

        if (luma < LumaEdge0)
            band_next = strength_ext <<< 1;
        else if (luma < LumaEdge1)
            band_next = strength_ext;
        else if (luma < LumaEdge2)
            band_next = '0;
        else if (luma < LumaEdge3)
            band_next = -strength_ext;
        else
            band_next = -(strength_ext <<< 1);

        // The floored sum never exceeds 229, so only the negative side clamps.
        if (warm_sum_reg[16])
            warm_byte = 8'd0;
        else
            warm_byte = warm_sum_reg[15:8];

        warm_ext      = {{(WarmProdWidth - 8){1'b0}}, warm_byte};
        strength_wide = {{(WarmProdWidth - StrengthWidth){strength[StrengthWidth-1]}},
                         strength};

        data_next.pix       = pix1_reg;
        data_next.band      = band_next;
        data_next.warm_prod = warm_ext * strength_wide;
    end

    always_ff @(posedge clk)
    begin
        if (load.ld2)
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

FILE: rtl/ptca_offset_stage.sv
module ptca_offset_stage
    import ptca_pkg::*;
(
    input  logic         clk,
    input  pipe_load_t   load,
    input  color_data_t  data_in,
    output offset_data_t data_out
);

    logic signed [WarmFullWidth-1:0] prod_wide;
    logic signed [WarmFullWidth-1:0] warm_full;
    logic signed [BandWidth-1:0]     warm_term;
    offset_data_t                    data_reg;
    offset_data_t                    data_next;

    always_comb
    begin
        prod_wide = {{(WarmFullWidth - WarmProdWidth){data_in.warm_prod[WarmProdWidth-1]}},
                     data_in.warm_prod};
        warm_full = prod_wide * WarmGain;
        // Taking the upper bits of a two's complement value floors the shift.
        warm_term = {{(BandWidth - (WarmFullWidth - 16)){warm_full[WarmFullWidth-1]}},
                     warm_full[WarmFullWidth-1:16]};

        data_next.pix   = data_in.pix;
        data_next.total = data_in.band + warm_term;
    end

    always_ff @(posedge clk)
    begin
        if (load.ld3)
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

FILE: rtl/ptca_clamp_stage.sv
module ptca_clamp_stage
    import ptca_pkg::*;
(
    input  logic         clk,
    input  pipe_load_t   load,
    input  offset_data_t data_in,
    output pixel_t       pix_out
);

    pixel_t pix_reg;
    pixel_t pix_next;

    function automatic logic [7:0] add_sat(input logic [7:0] chan,
                                           input logic signed [BandWidth-1:0] offs);
        logic signed [BandWidth:0] sum;
        begin
            sum = $signed({{(BandWidth - 7){1'b0}}, chan})
                + $signed({offs[BandWidth-1], offs});
            if (sum[BandWidth])
                add_sat = 8'd0;
            else if (sum[BandWidth-1:8] != '0)
                add_sat = 8'hFF;
            else
                add_sat = sum[7:0];
        end
    endfunction

    always_comb
    begin
        pix_next.red   = add_sat(data_in.pix.red,   data_in.total);
        pix_next.green = add_sat(data_in.pix.green, data_in.total);
        pix_next.blue  = add_sat(data_in.pix.blue,  data_in.total);
        pix_next.alpha = data_in.pix.alpha;
    end

    always_ff @(posedge clk)
    begin
        if (load.ld4)
            pix_reg <= pix_next;
    end

    assign pix_out = pix_reg;

endmodule

FILE: rtl/pixel_tone_curve_adjust_unit.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// input     | in_valid / in_stall   | red_in, green_in, blue_in, alpha_in
// output    | out_valid / out_stall | red_out, green_out, blue_out, alpha_out
// config    | cfg_we                | cfg_wdata (strength, signed integer)
//
// One pixel per clock is sustained while out_stall is low; the pixel passes through the
// four register stages (sums, band and warm product, offset, saturation), the first of
// which captures the pixel at the transfer edge; out_valid rises when the last one loads.
// Reset clears the valid bits of all stages and the strength register to zero.
// A stall on the output holds the output register; stages behind it keep
// filling until each holds a pixel, and only then is in_stall raised.
`include "pixel_tone_curve_adjust_unit_macros.svh"

module pixel_tone_curve_adjust_unit
    import ptca_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [StrengthWidth-1:0] cfg_wdata,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               red_in,
    input  logic [7:0]               green_in,
    input  logic [7:0]               blue_in,
    input  logic [7:0]               alpha_in,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               red_out,
    output logic [7:0]               green_out,
    output logic [7:0]               blue_out,
    output logic [7:0]               alpha_out
);

    logic signed [StrengthWidth-1:0] strength_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;

    logic ce1;
    logic ce2;
    logic ce3;
    logic ce4;

    pipe_load_t   load;
    pixel_t       pix_in;
    color_data_t  s2_data;
    offset_data_t s3_data;
    pixel_t       pix_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strength_reg <= '0;
        else if (cfg_we)
            strength_reg <= $signed(cfg_wdata);
    end

    // A stage moves when it is empty or when the stage after it moves.
    always_comb
    begin
        ce4 = !out_valid_reg || !out_stall;
        ce3 = !v3_reg || ce4;
        ce2 = !v2_reg || ce3;
        ce1 = !v1_reg || ce2;

        load.ld1 = ce1 && in_valid;
        load.ld2 = ce2 && v1_reg;
        load.ld3 = ce3 && v2_reg;
        load.ld4 = ce4 && v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ce1)
                v1_reg <= in_valid;
            if (ce2)
                v2_reg <= v1_reg;
            if (ce3)
                v3_reg <= v2_reg;
            if (ce4)
                out_valid_reg <= v3_reg;
        end
    end

    assign in_stall     = !ce1;
    assign pix_in.red   = red_in;
    assign pix_in.green = green_in;
    assign pix_in.blue  = blue_in;
    assign pix_in.alpha = alpha_in;

    ptca_color_stage u_color
    (
        .clk      (clk),
        .load     (load),
        .strength (strength_reg),
        .pix_in   (pix_in),
        .data_out (s2_data)
    );

    ptca_offset_stage u_offset
    (
        .clk      (clk),
        .load     (load),
        .data_in  (s2_data),
        .data_out (s3_data)
    );

    ptca_clamp_stage u_clamp
    (
        .clk      (clk),
        .load     (load),
        .data_in  (s3_data),
        .pix_out  (pix_out)
    );

    assign out_valid = out_valid_reg;
    assign red_out   = pix_out.red;
    assign green_out = pix_out.green;
    assign blue_out  = pix_out.blue;
    assign alpha_out = pix_out.alpha;

    // Input is refused only when every stage holds a pixel and the output waits.
    `PTCA_ASSERT_IMPLY(a_stall_only_when_full, in_stall, v1_reg && v2_reg && v3_reg && out_valid_reg && out_stall)
    // A blocked second stage keeps its pixel and its data.
    `PTCA_ASSERT_NEXT(a_s2_holds, v2_reg && !ce3, v2_reg && $stable(s2_data))
    // A new result only appears when the offset stage held one.
    `PTCA_ASSERT_IMPLY(a_out_from_s3, $rose(out_valid_reg), $past(v3_reg))

endmodule

FILE: tb/pixel_tone_curve_adjust_unit_tb.sv
`timescale 1ns / 1ps

module pixel_tone_curve_adjust_unit_tb;
    import ptca_pkg::*;

    localparam int CycleLimit    = 200000;
    localparam int DirRows       = 23;
    localparam int RandPhases    = 10;
    localparam int ItemsPerPhase = 105;
    localparam int DrainCycles   = 8;

    typedef enum logic [1:0] {
        StallNone,
        StallLight,
        StallPattern,
        StallHeavy
    } stall_mode_e;

    typedef struct packed {
        logic signed [StrengthWidth-1:0] strength;
        pixel_t                          pix;
        logic                            typed;
        pixel_t                          want;
    } tone_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [StrengthWidth-1:0] cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [7:0]               red_in = '0;
    logic [7:0]               green_in = '0;
    logic [7:0]               blue_in = '0;
    logic [7:0]               alpha_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [7:0]               red_out;
    logic [7:0]               green_out;
    logic [7:0]               blue_out;
    logic [7:0]               alpha_out;

    logic signed [StrengthWidth-1:0] strength_shadow = '0;
    pixel_t      pending_pixels[$];
    stall_mode_e stall_mode = StallNone;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    int          errors = 0;
    int          cycles = 0;

    // Gray pixels of value v have luma v-1, so each band edge is hit from both sides.
    tone_row_t dir_rows [DirRows] = '{
        '{13'sd0, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{13'sd0, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{13'sd0, '{8'd18, 8'd200, 8'd90, 8'd128}, 1'b1, '{8'd18, 8'd200, 8'd90, 8'd128}},
        '{13'sd4095, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
        '{13'sd4095, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{13'sd4095, '{8'd26, 8'd26, 8'd26, 8'd1}, 1'b0, '0},
        '{13'sd4095, '{8'd27, 8'd27, 8'd27, 8'd2}, 1'b0, '0},
        '{13'sd4095, '{8'd77, 8'd77, 8'd77, 8'd4}, 1'b0, '0},
        '{13'sd4095, '{8'd78, 8'd78, 8'd78, 8'd8}, 1'b0, '0},
        '{13'sd4095, '{8'd179, 8'd179, 8'd179, 8'd16}, 1'b0, '0},
        '{13'sd4095, '{8'd180, 8'd180, 8'd180, 8'd32}, 1'b0, '0},
        '{13'sd4095, '{8'd230, 8'd230, 8'd230, 8'd64}, 1'b0, '0},
        '{13'sd4095, '{8'd231, 8'd231, 8'd231, 8'd127}, 1'b0, '0},
        '{13'sd4095, '{8'd0, 8'd0, 8'd255, 8'd77}, 1'b0, '0},
        '{13'sd4095, '{8'd255, 8'd128, 8'd0, 8'd200}, 1'b0, '0},
        '{13'h1000, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{13'h1000, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{13'h1000, '{8'd255, 8'd0, 8'd0, 8'd9}, 1'b0, '0},
        '{13'h1000, '{8'd0, 8'd255, 8'd0, 8'd250}, 1'b0, '0},
        '{13'sd2560, '{8'd100, 8'd60, 8'd20, 8'd3}, 1'b0, '0},
        '{-13'sd2560, '{8'd100, 8'd60, 8'd20, 8'd3}, 1'b0, '0},
        '{13'sd1, '{8'd120, 8'd130, 8'd140, 8'd66}, 1'b0, '0},
        '{-13'sd1, '{8'd120, 8'd130, 8'd140, 8'd66}, 1'b0, '0}
    };

    pixel_tone_curve_adjust_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] sat_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic pixel_t predict_tone(input pixel_t p,
                                            input logic signed [StrengthWidth-1:0] s);
        int     r;
        int     g;
        int     b;
        int     sv;
        int     luma;
        int     band;
        int     warm;
        int     total;
        pixel_t res;
        r = p.red;
        g = p.green;
        b = p.blue;
        sv = s;
        luma = (int'(LumaCoefR) * r + int'(LumaCoefG) * g + int'(LumaCoefB) * b) >>> 8;
        if (luma < int'(LumaEdge0))
            band = 2 * sv;
        else if (luma < int'(LumaEdge1))
            band = sv;
        else if (luma < int'(LumaEdge2))
            band = 0;
        else if (luma < int'(LumaEdge3))
            band = -sv;
        else
            band = -2 * sv;
        // The arithmetic shift floors negative sums, which then clamp to zero.
        warm = sat_byte((int'(WarmCoefR) * r + int'(WarmCoefG) * g
                         - int'(WarmCoefB) * b) >>> 8);
        total = band + ((warm * sv * int'(WarmGain)) >>> 16);
        res.red = sat_byte(r + total);
        res.green = sat_byte(g + total);
        res.blue = sat_byte(b + total);
        res.alpha = p.alpha;
        return res;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     pick;
        int     edge_val;
        pick = $urandom_range(0, 99);
        p = $urandom;
        if (pick < 15)
        begin
            case ($urandom_range(0, 3))
                0: edge_val = int'(LumaEdge0);
                1: edge_val = int'(LumaEdge1);
                2: edge_val = int'(LumaEdge2);
                default: edge_val = int'(LumaEdge3);
            endcase
            edge_val = edge_val + $urandom_range(0, 4) - 1;
            p.red = edge_val[7:0];
            p.green = edge_val[7:0];
            p.blue = edge_val[7:0];
        end
        else if (pick < 30)
        begin
            p.red = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            p.green = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            p.blue = ($urandom_range(0, 2) == 0) ? p.blue : 8'd0;
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_strength(input logic signed [StrengthWidth-1:0] s);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        strength_shadow = s;
    endtask

    task automatic send_pixel(input pixel_t p, input logic typed, input pixel_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        red_in <= p.red;
        green_in <= p.green;
        blue_in <= p.blue;
        alpha_in <= p.alpha;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pixels.push_back(typed ? want : predict_tone(p, strength_shadow));
    endtask

    // The receiver stalls on its own schedule, changed between phases.
    always @(posedge clk)
    begin
        case (stall_mode)
            StallNone:    out_stall <= 1'b0;
            StallLight:   out_stall <= ($urandom_range(0, 3) == 0);
            StallPattern: out_stall <= ((cycles % 7) < 3);
            default:      out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: output transfer with no pixel pending, actual %0d %0d %0d %0d",
                         $time, red_out, green_out, blue_out, alpha_out);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red_out", want.red, red_out);
                check_field("green_out", want.green, green_out);
                check_field("blue_out", want.blue, blue_out);
                check_field("alpha_out", want.alpha, alpha_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic signed [StrengthWidth-1:0] s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_mode = StallLight;
        for (int i = 0; i < DirRows; i++)
        begin
            if (dir_rows[i].strength != strength_shadow)
                write_strength(dir_rows[i].strength);
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int phase = 0; phase < RandPhases; phase++)
        begin
            if (phase == 0)
                s = '0;
            else if ($urandom_range(0, 5) == 0)
                s = StrengthWidth'($urandom);
            else
                s = StrengthWidth'($urandom_range(0, 5120) - 2560);
            write_strength(s);
            gaps_on = (phase % 3) != 0;
            stall_mode = stall_mode_e'(phase % 4);
            for (int n = 0; n < ItemsPerPhase; n++)
                send_pixel(random_pixel(), 1'b0, '0);
        end

        drain_pipeline();
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
